// ----- hw/rtl/cahp_pkg.sv -----
package cahp_pkg;

  localparam int MaxLayersDefault = 16;
  localparam int HeaderBytes      = 4 + 24;
  localparam int BlockBytes       = 9;
  localparam int MaxDirections    = 64;
  localparam int QueueDepth       = 4;

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindLayer  = 2'd1;
  localparam logic [1:0] KindPrio   = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTruncated = 3'd1;
  localparam logic [2:0] StBadLayers = 3'd2;
  localparam logic [2:0] StBadFrames = 3'd3;
  localparam logic [2:0] StBadDirs   = 3'd4;
  localparam logic [2:0] StBadIndex  = 3'd5;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  status_code;
    logic [6:0]  direction;
    logic [7:0]  frame;
    logic [4:0]  slot;
    logic [7:0]  value_byte;
    logic [3:0]  composite_index;
    logic [31:0] shadow_trans;
    logic [31:0] weapon_code;
    logic [2:0]  weapon_length;
    logic        last_of_run;
  } out_t;

  // up to two records made by one byte, first one in rec0
  typedef struct packed {
    logic [1:0] vld;
    out_t       rec0;
    out_t       rec1;
  } pair_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == 8'h00);
  endfunction

endpackage

// ----- hw/rtl/composite_animation_header_parser.sv -----
// a record is built from its byte and written into the registered result queue
// throughput: one byte per cycle; a byte makes zero, one or two records and the
//   result queue drains one record per cycle, so bursts of two-record bytes stall push
// full rises when the result queue has fewer than two free entries
// reset: asynchronous, active low; parse restarts at the header, queue empties
module composite_animation_header_parser #(
  parameter int MAX_LAYERS = cahp_pkg::MaxLayersDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  cahp_pkg::in_t  in_item_i,
  output logic           empty,
  input  logic           pop,
  output cahp_pkg::out_t out_item_o
);
  import cahp_pkg::*;

  logic  accept;
  pair_t pair;

  // a byte is taken whenever the queue has room for two records
  assign accept = push && !full;

  // front: byte parser, makes the records of one item
  cahp_front #(
    .MAX_LAYERS(MAX_LAYERS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .pair_o   (pair)
  );

  // back: record queue towards the consumer
  cahp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (pair),
    .full_o     (full),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ----- hw/rtl/cahp_front.sv -----
module cahp_front #(
  parameter int MAX_LAYERS = cahp_pkg::MaxLayersDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  cahp_pkg::in_t   item_i,
  output cahp_pkg::pair_t pair_o
);
  import cahp_pkg::*;

  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  localparam logic [2:0] PhHeader    = 3'd0;
  localparam logic [2:0] PhLayers    = 3'd1;
  localparam logic [2:0] PhLayersBad = 3'd2;
  localparam logic [2:0] PhFlags     = 3'd3;
  localparam logic [2:0] PhPrio      = 3'd4;
  localparam logic [2:0] PhDone      = 3'd5;

  logic [2:0]            phase_q, phase_d;
  logic [4:0]            bc_q, bc_d;
  logic [7:0]            layers_q, layers_d;
  logic [7:0]            frames_q, frames_d;
  logic [7:0]            dirs_q, dirs_d;
  logic [CW-1:0]         blk_q, blk_d;
  logic [5:0]            dir_q, dir_d;
  logic [7:0]            frm_q, frm_d;
  logic [CW-1:0]         slot_q, slot_d;
  logic [63:0]           buf_q, buf_d;
  logic [MAX_LAYERS-1:0] seen_q, seen_d;

  logic [7:0]  b;
  logic        main_v, trunc_v;
  out_t        main_r, trunc_r;
  logic [7:0]  idx;
  logic [31:0] wc;
  logic [3:0]  blank;
  logic [2:0]  wl;
  logic [CW-1:0] blk_n, slot_n;
  logic [7:0]  frm_n;
  logic [6:0]  dir_n;
  logic [4:0]  bc_n;

  assign b   = item_i.data_byte;
  assign idx = buf_q[63:56];

  // trailing blank trim, lowest byte first
  always_comb begin
    wc = {buf_q[23:0], b};
    for (int i = 0; i < 4; i++) begin
      blank[i] = is_blank(wc[8*i +: 8]);
    end
    if (!blank[0]) begin
      wl = 3'd4;
    end else if (!blank[1]) begin
      wl = 3'd3;
      wc[7:0] = 8'h00;
    end else if (!blank[2]) begin
      wl = 3'd2;
      wc[15:0] = 16'h0000;
    end else if (!blank[3]) begin
      wl = 3'd1;
      wc[23:0] = 24'h000000;
    end else begin
      wl = 3'd0;
      wc = 32'h0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    bc_d     = bc_q;
    layers_d = layers_q;
    frames_d = frames_q;
    dirs_d   = dirs_q;
    blk_d    = blk_q;
    dir_d    = dir_q;
    frm_d    = frm_q;
    slot_d   = slot_q;
    buf_d    = buf_q;
    seen_d   = seen_q;
    main_v   = 1'b0;
    main_r   = '0;
    blk_n    = blk_q + CW'(1);
    slot_n   = slot_q + CW'(1);
    frm_n    = frm_q + 8'd1;
    dir_n    = {1'b0, dir_q} + 7'd1;
    bc_n     = bc_q + 5'd1;

    case (phase_q)
      PhHeader: begin
        if (bc_q == 5'd0) layers_d = b;
        if (bc_q == 5'd1) frames_d = b;
        if (bc_q == 5'd2) dirs_d = b;
        if (bc_q == 5'd3) buf_d = {56'h0, b};
        if (bc_q >= 5'(HeaderBytes - 1)) begin
          main_v = 1'b1;
          main_r.record_kind = KindStatus;
          if (layers_q == 8'd0 || layers_q > 8'(MAX_LAYERS)) begin
            main_r.status_code = StBadLayers;
            phase_d = PhDone;
          end else if (frames_q == 8'd0) begin
            main_r.status_code = StBadFrames;
            phase_d = PhDone;
          end else if (dirs_q == 8'd0 || dirs_q > 8'(MaxDirections)) begin
            main_r.status_code = StBadDirs;
            phase_d = PhDone;
          end else begin
            main_r.record_kind = KindHeader;
            main_r.direction   = dirs_q[6:0];
            main_r.frame       = frames_q;
            main_r.slot        = layers_q[4:0];
            main_r.value_byte  = buf_q[7:0];
            phase_d = PhLayers;
            bc_d    = 5'd0;
            blk_d   = '0;
          end
        end else begin
          bc_d = bc_n;
        end
      end
      PhLayers, PhLayersBad: begin
        if (phase_q == PhLayers) begin
          if (bc_q == 5'd0) begin
            if (b >= 8'(MAX_LAYERS)) begin
              phase_d = PhLayersBad;
            end else begin
              buf_d = {56'h0, b};
            end
          end else if (bc_q == 5'(BlockBytes - 1)) begin
            if (!seen_q[idx[IW-1:0]]) begin
              seen_d[idx[IW-1:0]] = 1'b1;
              main_v = 1'b1;
              main_r.record_kind     = KindLayer;
              main_r.composite_index = idx[3:0];
              main_r.shadow_trans    = buf_q[55:24];
              main_r.weapon_code     = wc;
              main_r.weapon_length   = wl;
            end
          end else begin
            buf_d = {buf_q[55:0], b};
          end
        end
        bc_d = bc_n;
        if (bc_n >= 5'(BlockBytes)) begin
          bc_d  = 5'd0;
          blk_d = blk_n;
          if (8'(blk_n) >= layers_q) begin
            if (phase_q == PhLayersBad) begin
              main_v = 1'b1;
              main_r.record_kind = KindStatus;
              main_r.status_code = StBadIndex;
              phase_d = PhDone;
            end else begin
              phase_d = PhFlags;
              frm_d   = 8'd0;
            end
          end
        end
      end
      PhFlags: begin
        frm_d = frm_n;
        if (frm_n >= frames_q) begin
          phase_d = PhPrio;
          dir_d   = 6'd0;
          frm_d   = 8'd0;
          slot_d  = '0;
        end
      end
      PhPrio: begin
        main_v = 1'b1;
        main_r.record_kind = KindPrio;
        main_r.direction   = {1'b0, dir_q};
        main_r.frame       = frm_q;
        main_r.slot        = 5'(slot_q);
        main_r.value_byte  = b;
        slot_d = slot_n;
        if (8'(slot_n) >= layers_q) begin
          slot_d = '0;
          frm_d  = frm_n;
          if (frm_n >= frames_q) begin
            frm_d = 8'd0;
            dir_d = dir_n[5:0];
            if ({1'b0, dir_n} >= dirs_q) begin
              main_v = 1'b1;
              phase_d = PhDone;
              // status closes the run in the second slot
            end
          end
        end
      end
      default: begin
      end
    endcase

    trunc_v = 1'b0;
    trunc_r = '0;
    trunc_r.record_kind = KindStatus;
    if (item_i.end_of_buffer) begin
      trunc_r.status_code = StTruncated;
      trunc_v = (phase_d != PhDone);
      phase_d  = PhHeader;
      bc_d     = 5'd0;
      layers_d = 8'd0;
      frames_d = 8'd0;
      dirs_d   = 8'd0;
      blk_d    = '0;
      dir_d    = 6'd0;
      frm_d    = 8'd0;
      slot_d   = '0;
      seen_d   = '0;
    end
  end

  // a priority byte that ends the run makes a priority record and an ok status
  logic prio_end;
  out_t ok_r;
  assign prio_end = (phase_q == PhPrio) && (phase_d == PhDone || item_i.end_of_buffer)
                    && main_v && (8'(slot_n) >= layers_q) && (frm_n >= frames_q)
                    && ({1'b0, dir_n} >= dirs_q);

  always_comb begin
    ok_r = '0;
    ok_r.record_kind = KindStatus;
    ok_r.status_code = StOk;
    ok_r.last_of_run = 1'b1;
    pair_o = '0;
    if (prio_end) begin
      pair_o.vld  = 2'b11;
      pair_o.rec0 = main_r;
      pair_o.rec1 = ok_r;
    end else if (main_v) begin
      pair_o.rec0 = main_r;
      pair_o.vld[0] = 1'b1;
      if (trunc_v) begin
        pair_o.rec1 = trunc_r;
        pair_o.rec1.last_of_run = 1'b1;
        pair_o.vld[1] = 1'b1;
      end else begin
        pair_o.rec0.last_of_run = 1'b1;
      end
    end else if (trunc_v) begin
      pair_o.rec0 = trunc_r;
      pair_o.rec0.last_of_run = 1'b1;
      pair_o.vld[0] = 1'b1;
    end
    if (!accept_i) pair_o.vld = 2'b00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      bc_q     <= 5'd0;
      layers_q <= 8'd0;
      frames_q <= 8'd0;
      dirs_q   <= 8'd0;
      blk_q    <= '0;
      dir_q    <= 6'd0;
      frm_q    <= 8'd0;
      slot_q   <= '0;
      seen_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      bc_q     <= bc_d;
      layers_q <= layers_d;
      frames_q <= frames_d;
      dirs_q   <= dirs_d;
      blk_q    <= blk_d;
      dir_q    <= dir_d;
      frm_q    <= frm_d;
      slot_q   <= slot_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) buf_q <= buf_d;
  end

endmodule

// ----- hw/rtl/cahp_queue.sv -----
module cahp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cahp_pkg::pair_t pair_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output cahp_pkg::out_t  out_item_o
);
  import cahp_pkg::*;

  localparam int PW = $clog2(QueueDepth);
  localparam int CNW = $clog2(QueueDepth + 1);

  out_t           mem_q [QueueDepth];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [1:0]     nwr;
  logic           do_pop;

  assign nwr     = {1'b0, pair_i.vld[0]} + {1'b0, pair_i.vld[1]};
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q > CNW'(QueueDepth - 2));
  assign do_pop  = pop_i && !empty_o;
  assign out_item_o = mem_q[rd_q];
  assign cnt_d   = cnt_q + CNW'(nwr) - CNW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (pair_i.vld[0]) mem_q[wr_q] <= pair_i.rec0;
    if (pair_i.vld[1]) mem_q[wr_q + PW'(1)] <= pair_i.rec1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(nwr);
      rd_q  <= rd_q + PW'(do_pop);
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(QueueDepth))
    else $error("queue count above depth");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (pair_i.vld == 2'b00))
    else $error("write into full queue");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && pair_i.vld == 2'b00) |=> (cnt_q == $past(cnt_q) - CNW'(1)))
    else $error("pop did not drop count");

endmodule
